/* rtl/core/mss_pkg.sv */
// Shared constants and stage-to-stage types for the maximal square finder.
// No dependencies; every other file in rtl/core imports this package.
package mss_pkg;

  localparam int unsigned MaxColumns = 1024;
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned RowW       = 11;
  localparam int unsigned SideW      = 11;
  localparam int unsigned AreaW      = 21;

  localparam logic [RowW-1:0]  RowWidthReset = RowW'(MaxColumns);
  localparam logic [RowW-1:0]  RowWidthMax   = RowW'(MaxColumns);
  localparam logic [SideW-1:0] SideMax       = '1;
  localparam logic [AreaW-1:0] AreaMax       = '1;

  // Pixel as it leaves the scan cell, registered in the cycle after its transfer.
  typedef struct packed {
    logic            vld;
    logic            pixel;
    logic            frame_end;
    logic            border;     // first row or first column
    logic            row_end;
    logic [ColW-1:0] col;
  } scan_tok_t;

  // Frame result as it leaves the side cell.
  typedef struct packed {
    logic             vld;
    logic [SideW-1:0] best;
  } best_tok_t;

endpackage

/* rtl/core/mss_if.sv */
// Handshake channels of the maximal square finder: pixels, results, row width.
// Depends on mss_pkg for the payload widths.
interface mss_pix_if;
  import mss_pkg::*;
  logic valid;
  logic ready;
  logic pixel;
  logic frame_end;
  modport source (output valid, output pixel, output frame_end, input ready);
  modport sink   (input valid, input pixel, input frame_end, output ready);
endinterface

interface mss_res_if;
  import mss_pkg::*;
  logic             valid;
  logic             ready;
  logic [SideW-1:0] best_side;
  logic [AreaW-1:0] best_area;
  modport source (output valid, output best_side, output best_area, input ready);
  modport sink   (input valid, input best_side, input best_area, output ready);
endinterface

interface mss_cfg_if;
  import mss_pkg::*;
  logic            valid;
  logic            ready;
  logic [RowW-1:0] row_width;
  modport source (output valid, output row_width, input ready);
  modport sink   (input valid, input row_width, output ready);
endinterface

/* rtl/core/mss_scan_cell.sv */
// Scan cell: tracks the raster position and issues the line buffer read.
// Depends on mss_pkg; feeds mss_side_cell.
module mss_scan_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     pix_vld_i,
  input  logic                     pixel_i,
  input  logic                     frame_end_i,
  input  logic [mss_pkg::RowW-1:0] row_width_i,
  output logic                     rd_en_o,
  output logic [mss_pkg::ColW-1:0] rd_addr_o,
  output mss_pkg::scan_tok_t       tok_o
);
  import mss_pkg::*;

  logic [ColW-1:0] col_q, col_d;
  logic            first_q, first_d;
  logic [RowW-1:0] width_eff;
  logic            row_end;
  logic            acc;
  scan_tok_t       tok_q, tok_d;

  assign acc = pix_vld_i & adv_i;

  always_comb begin
    if (row_width_i == '0) begin
      width_eff = RowW'(1);
    end else if (row_width_i > RowWidthMax) begin
      width_eff = RowWidthMax;
    end else begin
      width_eff = row_width_i;
    end
    row_end = ({1'b0, col_q} + RowW'(1)) >= width_eff;

    col_d   = col_q;
    first_d = first_q;
    if (acc) begin
      if (frame_end_i) begin
        col_d   = '0;
        first_d = 1'b1;
      end else if (row_end) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d = col_q + ColW'(1);
      end
    end

    tok_d           = tok_q;
    if (adv_i) begin
      tok_d.vld       = pix_vld_i;
      tok_d.pixel     = pixel_i;
      tok_d.frame_end = frame_end_i;
      tok_d.border    = first_q | (col_q == '0);
      tok_d.row_end   = row_end;
      tok_d.col       = col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
      tok_q   <= '0;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
      tok_q   <= tok_d;
    end
  end

  assign rd_en_o   = acc;
  assign rd_addr_o = col_q;
  assign tok_o     = tok_q;

endmodule

/* rtl/core/mss_side_cell.sv */
// Side cell: holds the line buffer of the previous row's sides, computes the
// square side of each pixel and keeps the running best. Depends on mss_pkg.
module mss_side_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     rd_en_i,
  input  logic [mss_pkg::ColW-1:0] rd_addr_i,
  input  mss_pkg::scan_tok_t       tok_i,
  output mss_pkg::best_tok_t       res_o
);
  import mss_pkg::*;

  logic [SideW-1:0] line_mem [MaxColumns];
  logic [SideW-1:0] rd_data_q;
  logic             fwd_q;
  logic [SideW-1:0] fwd_side_q;
  logic [SideW-1:0] left_q, ul_q, best_q;
  logic [SideW-1:0] upper, min_lu, min3, side, best_nx;
  logic [SideW:0]   inc;
  best_tok_t        res_q;
  logic             take;

  assign take = adv_i & tok_i.vld;

  always_comb begin
    // The read issued with the next pixel may hit the entry written this cycle.
    upper   = fwd_q ? fwd_side_q : rd_data_q;
    min_lu  = (left_q < upper) ? left_q : upper;
    min3    = (min_lu < ul_q) ? min_lu : ul_q;
    inc     = {1'b0, min3} + (SideW + 1)'(1);
    if (!tok_i.pixel) begin
      side = '0;
    end else if (tok_i.border) begin
      side = SideW'(1);
    end else if (inc[SideW]) begin
      side = SideMax;
    end else begin
      side = inc[SideW-1:0];
    end
    best_nx = (side > best_q) ? side : best_q;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      line_mem[tok_i.col] <= side;
    end
    if (rd_en_i) begin
      rd_data_q <= line_mem[rd_addr_i];
    end
    if (adv_i) begin
      fwd_side_q <= side;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= 1'b0;
      left_q <= '0;
      ul_q   <= '0;
      best_q <= '0;
      res_q  <= '0;
    end else begin
      if (adv_i) begin
        fwd_q     <= rd_en_i & tok_i.vld & (tok_i.col == rd_addr_i);
        res_q.vld <= take & tok_i.frame_end;
        if (take) begin
          res_q.best <= best_nx;
        end
      end
      if (take) begin
        if (tok_i.frame_end) begin
          left_q <= '0;
          ul_q   <= '0;
          best_q <= '0;
        end else if (tok_i.row_end) begin
          left_q <= '0;
          ul_q   <= '0;
          best_q <= best_nx;
        end else begin
          left_q <= side;
          ul_q   <= upper;
          best_q <= best_nx;
        end
      end
    end
  end

  assign res_o = res_q;

  a_res_from_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_q.vld) |-> $past(adv_i && tok_i.vld && tok_i.frame_end))
    else $error("result raised without a frame end pixel");

  a_left_within_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= best_q)
    else $error("left side exceeds running best");

  a_fwd_needs_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(tok_i.vld))
    else $error("line buffer bypass without a pixel in flight");

endmodule

/* rtl/core/mss_area_cell.sv */
// Area cell: squares the best side and holds the result for the output port.
// Depends on mss_pkg and the interfaces in mss_if.sv.
module mss_area_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mss_pkg::best_tok_t res_i,
  output logic               adv_o,
  mss_res_if.source          res_o
);
  import mss_pkg::*;

  logic                 out_vld_q;
  logic [SideW-1:0]     out_best_q;
  logic [AreaW-1:0]     out_area_q;
  logic [2*SideW-1:0]   prod;
  logic [AreaW-1:0]     area_sat;
  logic                 load;

  // The chain only has to hold when a second result reaches a full output register.
  assign load  = ~out_vld_q | res_o.ready;
  assign adv_o = load | ~res_i.vld;

  always_comb begin
    prod = {{SideW{1'b0}}, res_i.best} * {{SideW{1'b0}}, res_i.best};
    if (prod[2*SideW-1:AreaW] != '0) begin
      area_sat = AreaMax;
    end else begin
      area_sat = prod[AreaW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= res_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && res_i.vld) begin
      out_best_q <= res_i.best;
      out_area_q <= area_sat;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.best_side = out_best_q;
  assign res_o.best_area = out_area_q;

endmodule

/* rtl/core/maximal_square_of_ones.sv */
// Maximal all-ones square finder: top level joining the scan, side and area cells.
// Depends on mss_pkg, mss_if.sv and the three mss_*_cell modules.
//
// Pixels arrive in raster order, row_width pixels per row, and one pixel is
// taken every clock cycle unless the chain holds. A pixel passes the scan cell
// (position and line buffer read), the side cell (square side from the left,
// upper and upper-left neighbors, running best) and, for the pixel that ends
// the frame, the area cell, which registers the side and its square. The result
// is valid once that pixel has passed the scan, side and area registers. The
// previous row is kept in a single-port-read line buffer of 1024 sides, read
// ahead by the scan cell, with a bypass for the entry written in that same
// cycle; it needs no clearing after reset. The only stall comes from the result
// port: a result waiting in the output register lets pixels flow until the next
// frame result reaches the side cell, and only then does the whole chain hold.
// Write row_width only while no frame is in flight.
module maximal_square_of_ones (
  input  logic      clk_i,
  input  logic      rst_ni,
  mss_pix_if.sink   pix_i,
  mss_cfg_if.sink   cfg_i,
  mss_res_if.source res_o
);
  import mss_pkg::*;

  logic            adv;
  logic            rd_en;
  logic [ColW-1:0] rd_addr;
  logic [RowW-1:0] row_width_q;
  scan_tok_t       tok;
  best_tok_t       best_tok;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= RowWidthReset;
    end else if (cfg_i.valid) begin
      row_width_q <= cfg_i.row_width;
    end
  end

  mss_scan_cell u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .pix_vld_i   (pix_i.valid),
    .pixel_i     (pix_i.pixel),
    .frame_end_i (pix_i.frame_end),
    .row_width_i (row_width_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .tok_o       (tok)
  );

  mss_side_cell u_side (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .tok_i     (tok),
    .res_o     (best_tok)
  );

  mss_area_cell u_area (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (best_tok),
    .adv_o  (adv),
    .res_o  (res_o)
  );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for maximal_square_of_ones: streams binary images and checks results.
// Depends on mss_pkg and the mss_pix_if, mss_cfg_if and mss_res_if interfaces.
`timescale 1ns / 100ps

module tb;
  import mss_pkg::*;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned RandomPixels = 400;

  typedef enum logic [1:0] {
    STIM_PIXEL,
    STIM_ROW_WIDTH,
    STIM_DRAIN,
    STIM_HOLD_RESULTS
  } stim_kind_e;

  typedef enum logic [1:0] {
    PAT_NOISE,
    PAT_DENSE,
    PAT_SOLID,
    PAT_PLANTED
  } pattern_e;

  typedef struct packed {
    stim_kind_e      kind;
    logic            pixel;
    logic            frame_end;
    logic [RowW-1:0] row_width;
    logic            bursty;
  } stim_t;

  typedef struct packed {
    logic [SideW-1:0] side;
    logic [AreaW-1:0] area;
  } square_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic            pix_valid = 1'b0;
  logic            pix_data  = 1'b0;
  logic            pix_end   = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [RowW-1:0] cfg_data  = '0;
  logic            res_ready = 1'b0;
  logic            hold_kick = 1'b0;
  logic            bursty_q  = 1'b0;
  logic            feed_done = 1'b0;

  stim_t       stim_q[$];
  square_t     pending_squares[$];
  int unsigned frames_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned gap_left      = 0;
  int unsigned settle_left   = SettleCycles;
  int unsigned res_wait      = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned pixels_queued = 0;
  logic        gen_bursty    = 1'b0;

  // Scan state of the square predictor.
  logic [SideW-1:0] line_sides [MaxColumns];
  logic [SideW-1:0] left_side_q;
  logic [SideW-1:0] diag_side_q;
  logic [SideW-1:0] best_run;
  logic [ColW-1:0]  scan_col;
  logic             top_row;
  logic [RowW-1:0]  row_width_q;

  mss_pix_if pix_if ();
  mss_cfg_if cfg_if ();
  mss_res_if res_if ();

  assign pix_if.valid     = pix_valid;
  assign pix_if.pixel     = pix_data;
  assign pix_if.frame_end = pix_end;
  assign cfg_if.valid     = cfg_valid;
  assign cfg_if.row_width = cfg_data;
  assign res_if.ready     = res_ready;

  maximal_square_of_ones i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_width(input int unsigned w);
    if (w < 1) return 1;
    if (w > MaxColumns) return MaxColumns;
    return w;
  endfunction

  function automatic int unsigned draw_wait(input logic bursty);
    return bursty ? $urandom_range(0, 3) : 0;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0.1f ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advances the scan by one pixel and queues the frame result on a frame end.
  task automatic advance_square_scan(input logic px, input logic fe);
    int unsigned width, col, upper, side, sq;
    width = clamp_width(row_width_q);
    col   = scan_col;
    upper = line_sides[col];
    if (!px) begin
      side = 0;
    end else if (top_row || col == 0) begin
      side = 1;
    end else begin
      side = (left_side_q < upper) ? left_side_q : upper;
      side = (diag_side_q < side) ? diag_side_q : side;
      side = side + 1;
      if (side > SideMax) side = SideMax;
    end
    line_sides[col] = SideW'(side);
    diag_side_q     = SideW'(upper);
    left_side_q     = SideW'(side);
    if (side > best_run) best_run = SideW'(side);
    if (col + 1 >= width) begin
      scan_col    = '0;
      top_row     = 1'b0;
      left_side_q = '0;
      diag_side_q = '0;
    end else begin
      scan_col = ColW'(col + 1);
    end
    if (fe) begin
      sq = best_run * best_run;
      if (sq > AreaMax) sq = AreaMax;
      pending_squares.push_back('{side: best_run, area: AreaW'(sq)});
      frames_sent++;
      scan_col    = '0;
      left_side_q = '0;
      diag_side_q = '0;
      top_row     = 1'b1;
      best_run    = '0;
    end
  endtask

  task automatic queue_pixel(input logic px, input logic fe);
    stim_q.push_back('{kind: STIM_PIXEL, pixel: px, frame_end: fe, row_width: '0,
                       bursty: gen_bursty});
    pixels_queued++;
  endtask

  task automatic queue_control(input stim_kind_e kind, input int unsigned w);
    stim_q.push_back('{kind: kind, pixel: 1'b0, frame_end: 1'b0, row_width: RowW'(w),
                       bursty: gen_bursty});
  endtask

  task automatic queue_frame(input int unsigned w, input int unsigned npix, input pattern_e pat);
    int unsigned eff, rows, side, r0, c0, r, c;
    logic px;
    eff  = clamp_width(w);
    rows = (npix + eff - 1) / eff;
    side = $urandom_range(1, (rows < eff) ? rows : eff);
    r0   = $urandom_range(0, rows - side);
    c0   = $urandom_range(0, eff - side);
    for (int unsigned i = 0; i < npix; i++) begin
      r = i / eff;
      c = i % eff;
      case (pat)
        PAT_NOISE: px = 1'($urandom_range(0, 1));
        PAT_DENSE: px = ($urandom_range(0, 7) != 0);
        PAT_SOLID: px = 1'b1;
        default:   px = (r >= r0 && r < r0 + side && c >= c0 && c < c0 + side) ||
                        ($urandom_range(0, 5) == 0);
      endcase
      queue_pixel(px, i == npix - 1);
    end
  endtask

  // Pixel and register driver. Register writes and drains wait until every frame
  // result has been taken and the pipeline has had time to settle.
  always @(posedge clk_i or negedge rst_ni) begin : feed_stimulus
    stim_t head;
    logic  nx_pix, nx_cfg, nx_kick;
    if (!rst_ni) begin
      pix_valid   <= 1'b0;
      cfg_valid   <= 1'b0;
      hold_kick   <= 1'b0;
      feed_done   <= 1'b0;
      gap_left    = 0;
      settle_left = SettleCycles;
      row_width_q = RowWidthReset;
      scan_col    = '0;
      left_side_q = '0;
      diag_side_q = '0;
      best_run    = '0;
      top_row     = 1'b1;
      foreach (line_sides[k]) line_sides[k] = '0;
    end else begin
      nx_pix  = pix_valid;
      nx_cfg  = cfg_valid;
      nx_kick = 1'b0;
      if (pix_valid && pix_if.ready) begin
        advance_square_scan(pix_data, pix_end);
        nx_pix   = 1'b0;
        gap_left = draw_wait(bursty_q);
      end
      if (cfg_valid && cfg_if.ready) begin
        row_width_q = cfg_data;
        nx_cfg      = 1'b0;
        gap_left    = draw_wait(bursty_q);
      end
      if (!nx_pix && !nx_cfg && stim_q.size() != 0) begin
        head = stim_q[0];
        case (head.kind)
          STIM_PIXEL: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              void'(stim_q.pop_front());
              pix_data <= head.pixel;
              pix_end  <= head.frame_end;
              bursty_q <= head.bursty;
              nx_pix   = 1'b1;
            end
          end
          STIM_HOLD_RESULTS: begin
            void'(stim_q.pop_front());
            nx_kick = 1'b1;
          end
          default: begin
            if (frames_sent != results_seen) begin
              settle_left = SettleCycles;
            end else if (settle_left != 0) begin
              settle_left--;
            end else begin
              void'(stim_q.pop_front());
              settle_left = SettleCycles;
              bursty_q    <= head.bursty;
              if (head.kind == STIM_ROW_WIDTH) begin
                cfg_data <= head.row_width;
                nx_cfg   = 1'b1;
              end
            end
          end
        endcase
      end
      pix_valid <= nx_pix;
      cfg_valid <= nx_cfg;
      hold_kick <= nx_kick;
      feed_done <= (stim_q.size() == 0) && !nx_pix && !nx_cfg;
    end
  end

  // Long receiver hold-off, counted here so the result side can back up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : collect_results
    square_t want;
    if (!rst_ni) begin
      res_ready    <= 1'b0;
      results_seen <= 0;
      res_wait     = 0;
    end else begin
      if (res_if.valid && res_ready) begin
        results_seen <= results_seen + 1;
        if (pending_squares.size() == 0) begin
          flag_mismatch($sformatf("result side %0d area %0d with no frame pending",
                                  res_if.best_side, res_if.best_area));
        end else begin
          want = pending_squares.pop_front();
          if (res_if.best_side !== want.side)
            flag_mismatch($sformatf("best_side %0d, expected %0d", res_if.best_side, want.side));
          if (res_if.best_area !== want.area)
            flag_mismatch($sformatf("best_area %0d, expected %0d", res_if.best_area, want.area));
        end
        res_wait = draw_wait(bursty_q);
      end else if (res_wait != 0) begin
        res_wait--;
      end
      res_ready <= (res_wait == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix_valid && pix_if.ready) || (cfg_valid && cfg_if.ready) ||
          (res_if.valid && res_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int unsigned w, eff, rows, npix, nframes;
    pattern_e    pat;

    // Directed images on the reset row width, then the narrow widths.
    queue_pixel(1'b1, 1'b1);
    queue_pixel(1'b0, 1'b1);
    queue_control(STIM_ROW_WIDTH, 0);
    queue_frame(0, 3, PAT_SOLID);
    queue_control(STIM_ROW_WIDTH, 2);
    queue_frame(2, 4, PAT_SOLID);
    queue_pixel(1'b1, 1'b0);
    queue_pixel(1'b1, 1'b0);
    queue_pixel(1'b0, 1'b0);
    queue_pixel(1'b1, 1'b1);
    queue_control(STIM_ROW_WIDTH, 3);
    queue_frame(3, 5, PAT_SOLID);
    queue_frame(3, 9, PAT_SOLID);

    // One result per pixel while the receiver holds off, so the block backs up.
    queue_control(STIM_ROW_WIDTH, 1);
    queue_control(STIM_HOLD_RESULTS, 0);
    repeat (40) queue_pixel(1'($urandom_range(0, 1)), 1'b1);

    pixels_queued = 0;
    while (pixels_queued < RandomPixels) begin
      case ($urandom_range(0, 19))
        0:       w = 0;
        1:       w = $urandom_range(0, 1) ? (1 << RowW) - 1 : MaxColumns;
        2:       w = 1;
        default: w = $urandom_range(2, 40);
      endcase
      eff        = clamp_width(w);
      gen_bursty = ($urandom_range(0, 3) != 0);
      queue_control(STIM_ROW_WIDTH, w);
      nframes = $urandom_range(1, 4);
      repeat (nframes) begin
        pat  = pattern_e'($urandom_range(0, 3));
        rows = $urandom_range(1, (160 / eff > 1) ? 160 / eff : 1);
        npix = (eff >= MaxColumns) ? $urandom_range(1, 40) : eff * rows;
        if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, npix);
        queue_frame(w, npix, pat);
        if ($urandom_range(0, 9) == 0) queue_control(STIM_DRAIN, 0);
      end
    end

    // The widest row, reached through an oversize setting, with the wrap into row two.
    gen_bursty = 1'b1;
    queue_control(STIM_ROW_WIDTH, (1 << RowW) - 1);
    queue_frame(MaxColumns, MaxColumns + $urandom_range(1, 8), PAT_SOLID);
    queue_control(STIM_ROW_WIDTH, RowWidthMax);
    queue_frame(MaxColumns, 12, PAT_DENSE);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!feed_done) @(posedge clk_i);
    while (results_seen != frames_sent) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (pending_squares.size() != 0)
      flag_mismatch($sformatf("%0d frame results never arrived", pending_squares.size()));
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
